>>> hdl/camera_frame_capture_unit_macros.svh
// ----------------------------------------------------------------------------
// Camera frame capture unit - assertion macros
// Shared property wrappers for the capture unit checkers.
// ----------------------------------------------------------------------------
`ifndef CAMERA_FRAME_CAPTURE_UNIT_MACROS_SVH
`define CAMERA_FRAME_CAPTURE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CFC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("capture unit check failed (same cycle)");

// next-cycle implication, disabled while reset is asserted
`define CFC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("capture unit check failed (next cycle)");

`endif

>>> hdl/cfc_pkg.sv
// ----------------------------------------------------------------------------
// Camera frame capture package
// Frame geometry, field widths, event and register codes.
// ----------------------------------------------------------------------------
package cfc_pkg;

	// frame buffer geometry
	localparam int unsigned LINE_PIXELS = 640;
	localparam int unsigned FRAME_LINES = 480;

	// field widths
	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned PIXEL_W = 8;
	localparam int unsigned ROW_W   = 9;
	localparam int unsigned COL_W   = 10;
	localparam int unsigned LINE_W  = 12;
	localparam int unsigned PCNT_W  = 13;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned CDATA_W = 12;

	localparam logic [PCNT_W-1:0] LINE_PIXELS_C = PCNT_W'(LINE_PIXELS);
	localparam logic [LINE_W-1:0] FRAME_LINES_C = LINE_W'(FRAME_LINES);
	localparam logic [PCNT_W-1:0] PCNT_MAX      = '1;
	localparam logic [LINE_W-1:0] LINE_MAX      = '1;
	localparam logic [LINE_W-1:0] END_LINE_RST  = LINE_W'(481);

	typedef enum logic [FUNC_W-1:0] {
		FN_PCLK  = 3'd0,
		FN_HSYNC = 3'd1,
		FN_VSYNC = 3'd2,
		FN_ARM   = 3'd3,
		FN_CLEAR = 3'd4
	} func_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_START_LINE  = 2'd0,
		CFG_END_LINE    = 2'd1,
		CFG_COLOUR_MODE = 2'd2
	} cfg_idx_t;

endpackage

>>> hdl/cfc_if.sv
// ----------------------------------------------------------------------------
// Camera frame capture channels
// Camera event input, frame buffer write output and register write channel.
// ----------------------------------------------------------------------------
interface cfc_evt_if
	import cfc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [PIXEL_W-1:0] pixel_in;

	modport source (output valid, output func, output pixel_in, input ready);
	modport sink (input valid, input func, input pixel_in, output ready);
endinterface

interface cfc_wr_if
	import cfc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [ROW_W-1:0]   write_row;
	logic [COL_W-1:0]   write_column;
	logic [PIXEL_W-1:0] write_pixel;
	logic               frame_done;
	logic               capturing;

	modport source (output valid, output write_enable, output write_row,
		output write_column, output write_pixel, output frame_done,
		output capturing, input ready);
	modport sink (input valid, input write_enable, input write_row,
		input write_column, input write_pixel, input frame_done,
		input capturing, output ready);
endinterface

interface cfc_cfg_if
	import cfc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/camera_frame_capture_unit.sv
// A result is registered and appears on frame_wr in the cycle after its event transfer.
// Throughput: one camera event per cycle; the result register frees as it is
// taken, so input stalls only while a result waits and frame_wr.ready is low.
// Reset: arst_n clears capture state, counters and the result valid flag, and
// loads the registers with start line 0, end line 481 and mono mode.
// ----------------------------------------------------------------------------
// Camera frame capture unit
// Single-frame capture from parallel camera sync events into frame buffer
// write commands.
// ----------------------------------------------------------------------------
module camera_frame_capture_unit
	import cfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cfc_evt_if.sink   cam_evt,
	cfc_wr_if.source  frame_wr,
	cfc_cfg_if.sink   cfg
);

	logic [LINE_W-1:0] start_line_q;
	logic [LINE_W-1:0] end_line_q;
	logic              colour_mode_q;

	logic              armed_q;
	logic              active_q;
	logic              done_q;
	logic              phase_q;
	logic [PCNT_W-1:0] pcnt_q;
	logic [LINE_W-1:0] lcnt_q;

	logic              out_valid_q;
	logic              we_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [PIXEL_W-1:0] pix_q;
	logic              done_out_q;
	logic              active_out_q;

	logic              evt_xfer;
	func_t             func;
	logic              row_neg;
	logic [LINE_W-1:0] row_diff;
	logic              phase_n;
	logic              take;
	logic              in_window;
	logic [LINE_W-1:0] last_line;
	logic [LINE_W-1:0] lcnt_inc;

	logic              armed_d;
	logic              active_d;
	logic              done_d;
	logic              phase_d;
	logic [PCNT_W-1:0] pcnt_d;
	logic [LINE_W-1:0] lcnt_d;
	logic              we_d;

	assign cam_evt.ready = !out_valid_q || frame_wr.ready;
	assign cfg.ready     = 1'b1;
	assign evt_xfer      = cam_evt.valid && cam_evt.ready;
	assign func          = func_t'(cam_evt.func);

	// stored row is line count minus start offset; negative while skipping
	assign row_neg   = lcnt_q < start_line_q;
	assign row_diff  = lcnt_q - start_line_q;
	assign phase_n   = ~phase_q;
	assign take      = active_q && (colour_mode_q ? !row_neg : phase_n);
	assign in_window = !row_neg && (row_diff < FRAME_LINES_C) && (pcnt_q < LINE_PIXELS_C);
	assign last_line = (end_line_q == '0) ? '0 : end_line_q - LINE_W'(1);
	assign lcnt_inc  = (lcnt_q < LINE_MAX) ? lcnt_q + LINE_W'(1) : lcnt_q;

	always_comb begin
		armed_d  = armed_q;
		active_d = active_q;
		done_d   = done_q;
		phase_d  = phase_q;
		pcnt_d   = pcnt_q;
		lcnt_d   = lcnt_q;
		we_d     = 1'b0;
		unique case (func)
			FN_PCLK: begin
				phase_d = phase_n;
				if (take) begin
					we_d = in_window;
					if (pcnt_q < PCNT_MAX)
						pcnt_d = pcnt_q + PCNT_W'(1);
				end
			end
			FN_HSYNC: begin
				if (active_q) begin
					if (pcnt_q >= LINE_PIXELS_C) begin
						pcnt_d  = '0;
						phase_d = 1'b0;
					end
					lcnt_d = lcnt_inc;
					if (lcnt_inc >= last_line) begin
						lcnt_d   = last_line;
						done_d   = 1'b1;
						active_d = 1'b0;
					end
				end
			end
			FN_VSYNC: begin
				if (armed_q && !done_q) begin
					lcnt_d   = '0;
					pcnt_d   = '0;
					active_d = 1'b1;
					armed_d  = 1'b0;
				end
			end
			FN_ARM:   armed_d = 1'b1;
			FN_CLEAR: done_d  = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_line_q  <= '0;
			end_line_q    <= END_LINE_RST;
			colour_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_START_LINE:  start_line_q  <= cfg.data;
				CFG_END_LINE:    end_line_q    <= cfg.data;
				CFG_COLOUR_MODE: colour_mode_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
			phase_q  <= 1'b0;
			pcnt_q   <= '0;
			lcnt_q   <= '0;
		end else if (evt_xfer) begin
			armed_q  <= armed_d;
			active_q <= active_d;
			done_q   <= done_d;
			phase_q  <= phase_d;
			pcnt_q   <= pcnt_d;
			lcnt_q   <= lcnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cam_evt.ready)
			out_valid_q <= cam_evt.valid;
	end

	// payload is zero when nothing is written
	always_ff @(posedge clk) begin
		if (evt_xfer) begin
			we_q         <= we_d;
			row_q        <= we_d ? row_diff[ROW_W-1:0] : '0;
			col_q        <= we_d ? pcnt_q[COL_W-1:0] : '0;
			pix_q        <= we_d ? cam_evt.pixel_in : '0;
			done_out_q   <= done_d;
			active_out_q <= active_d;
		end
	end

	assign frame_wr.valid        = out_valid_q;
	assign frame_wr.write_enable = we_q;
	assign frame_wr.write_row    = row_q;
	assign frame_wr.write_column = col_q;
	assign frame_wr.write_pixel  = pix_q;
	assign frame_wr.frame_done   = done_out_q;
	assign frame_wr.capturing    = active_out_q;

endmodule

>>> hdl/cfc_chk.sv
// ----------------------------------------------------------------------------
// Camera frame capture checker
// Port-level checks on the write channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "camera_frame_capture_unit_macros.svh"

module cfc_chk
	import cfc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               wr_valid,
	input logic               wr_ready,
	input logic               wr_enable,
	input logic [ROW_W-1:0]   wr_row,
	input logic [COL_W-1:0]   wr_column,
	input logic [PIXEL_W-1:0] wr_pixel,
	input logic               wr_done,
	input logic               wr_capturing
);

	logic                             wr_stall;
	logic                             wr_store;
	logic                             wr_in_frame;
	logic [ROW_W+COL_W+PIXEL_W+2:0]   wr_payload;

	assign wr_stall    = wr_valid && !wr_ready;
	assign wr_store    = wr_valid && wr_enable;
	assign wr_in_frame = (wr_row < ROW_W'(FRAME_LINES)) && (wr_column < COL_W'(LINE_PIXELS));
	assign wr_payload  = {wr_enable, wr_row, wr_column, wr_pixel, wr_done, wr_capturing};

	// pixels are only stored while a capture runs
	`CFC_ASSERT_IMP(a_write_needs_capture, clk, arst_n, wr_store, wr_capturing)

	// stored pixels stay inside the frame buffer
	`CFC_ASSERT_IMP(a_write_in_frame, clk, arst_n, wr_store, wr_in_frame)

	// a finished frame blocks restart until cleared
	`CFC_ASSERT_IMP(a_done_excl_capture, clk, arst_n, wr_valid, !(wr_done && wr_capturing))

	// a stalled result holds
	`CFC_ASSERT_NXT(a_stall_holds, clk, arst_n, wr_stall, wr_valid && $stable(wr_payload))

endmodule

bind camera_frame_capture_unit cfc_chk u_cfc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.wr_valid     (frame_wr.valid),
	.wr_ready     (frame_wr.ready),
	.wr_enable    (frame_wr.write_enable),
	.wr_row       (frame_wr.write_row),
	.wr_column    (frame_wr.write_column),
	.wr_pixel     (frame_wr.write_pixel),
	.wr_done      (frame_wr.frame_done),
	.wr_capturing (frame_wr.capturing)
);
